/* rtl/core/ppb_pkg.sv */
// Package for the ping-pong transmit buffer manager.
// Holds the sizing constants, operation codes and the payload and request structs.
// Used by ppb_ctrl, ppb_store and ping_pong_tx_buffer_manager; depends on nothing.
package ppb_pkg;

	localparam int BUFFER_DEPTH = 64;
	localparam int LEN_W = $clog2(BUFFER_DEPTH + 1);
	localparam int OFF_W = $clog2(BUFFER_DEPTH);
	localparam int ADDR_W = OFF_W + 1;
	localparam int MEM_DEPTH = 2 ** ADDR_W;
	localparam logic [LEN_W-1:0] DEPTH_LEN = LEN_W'(BUFFER_DEPTH);

	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam logic [7:0] CHAR_LF = 8'h0A;

	typedef enum logic [1:0] {
		OP_PUT  = 2'd0,
		OP_DONE = 2'd1,
		OP_READ = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] data_byte;
		logic       read_buffer;
		logic [5:0] read_offset;
	} in_item_t;

	typedef struct packed {
		logic       accepted;
		logic       start_transfer;
		logic       transfer_buffer;
		logic [6:0] byte_count;
		logic       engine_busy;
		logic [7:0] read_data;
	} out_item_t;

	typedef struct packed {
		logic       accepted;
		logic       start_transfer;
		logic       transfer_buffer;
		logic [6:0] byte_count;
		logic       engine_busy;
		logic       read_hit;
	} step_res_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} wr_req_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
	} rd_req_t;

endpackage

/* rtl/core/ppb_store.sv */
// Byte store shared by the two ping-pong buffers: one write port, one registered read port.
// The buffer index forms the top address bit. Depends on ppb_pkg.
module ppb_store (
	input  logic              clk,
	input  ppb_pkg::wr_req_t  wr,
	input  ppb_pkg::rd_req_t  rd,
	output logic [7:0]        rdata
);

	logic [7:0] mem [ppb_pkg::MEM_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			rdata <= mem[rd.addr];
		end
	end

endmodule

/* rtl/core/ppb_ctrl.sv */
// Buffer control for the ping-pong transmit buffer manager: fill counts, buffer roles,
// engine state, line-end detection and the store requests for one item. Depends on ppb_pkg.
module ppb_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                commit,
	input  ppb_pkg::in_item_t   item,
	output ppb_pkg::step_res_t  res,
	output ppb_pkg::wr_req_t    wr,
	output ppb_pkg::rd_req_t    rd
);

	logic [ppb_pkg::LEN_W-1:0] len_q [2];
	logic [ppb_pkg::LEN_W-1:0] len_n [2];
	logic [7:0]                last_q [2];
	logic [7:0]                last_n [2];
	logic                      fill_q, fill_n;
	logic                      drain_q, drain_n;
	logic                      act_q, act_n;
	logic                      f, g;
	logic [ppb_pkg::LEN_W-1:0] lenf, leng, start_len;
	logic                      pair;
	logic [31:0]               roff32;

	assign roff32 = 32'(item.read_offset);

	always_comb begin
		len_n = len_q;
		last_n = last_q;
		fill_n = fill_q;
		drain_n = drain_q;
		act_n = act_q;
		res = '0;
		wr = '0;
		f = fill_q;
		g = ~fill_q;
		lenf = len_q[f];
		leng = len_q[g];
		start_len = '0;
		pair = (last_q[f] == ppb_pkg::CHAR_CR && item.data_byte == ppb_pkg::CHAR_LF) ||
			(last_q[f] == ppb_pkg::CHAR_LF && item.data_byte == ppb_pkg::CHAR_CR);
		rd.en = commit;
		rd.addr = {item.read_buffer, roff32[ppb_pkg::OFF_W-1:0]};
		unique case (ppb_pkg::op_t'(item.operation))
			ppb_pkg::OP_PUT: begin
				if (lenf < ppb_pkg::DEPTH_LEN) begin
					wr.en = commit;
					wr.addr = {f, lenf[ppb_pkg::OFF_W-1:0]};
					wr.data = item.data_byte;
					len_n[f] = lenf + ppb_pkg::LEN_W'(1);
					last_n[f] = item.data_byte;
					res.accepted = 1'b1;
					if (lenf != '0 && pair && !act_q) begin
						res.start_transfer = 1'b1;
						res.transfer_buffer = f;
						start_len = lenf + ppb_pkg::LEN_W'(1);
						drain_n = f;
						fill_n = g;
						act_n = 1'b1;
					end
				end else if (!act_q) begin
					res.start_transfer = 1'b1;
					res.transfer_buffer = f;
					start_len = lenf;
					drain_n = f;
					fill_n = g;
					act_n = 1'b1;
					if (leng < ppb_pkg::DEPTH_LEN) begin
						wr.en = commit;
						wr.addr = {g, leng[ppb_pkg::OFF_W-1:0]};
						wr.data = item.data_byte;
						len_n[g] = leng + ppb_pkg::LEN_W'(1);
						last_n[g] = item.data_byte;
						res.accepted = 1'b1;
					end
				end
			end
			ppb_pkg::OP_DONE: begin
				if (act_q) begin
					act_n = 1'b0;
					len_n[drain_q] = '0;
				end
				if (len_n[f] != '0) begin
					res.start_transfer = 1'b1;
					res.transfer_buffer = f;
					start_len = len_n[f];
					drain_n = f;
					fill_n = g;
					act_n = 1'b1;
				end
			end
			ppb_pkg::OP_READ: begin
				res.read_hit = roff32 < 32'(ppb_pkg::BUFFER_DEPTH);
			end
			default: begin
			end
		endcase
		res.byte_count = 7'(start_len);
		res.engine_busy = act_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q[0] <= '0;
			len_q[1] <= '0;
			fill_q <= 1'b0;
			drain_q <= 1'b1;
			act_q <= 1'b0;
		end else if (commit) begin
			len_q <= len_n;
			fill_q <= fill_n;
			drain_q <= drain_n;
			act_q <= act_n;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			last_q <= last_n;
		end
	end

`ifndef SYNTHESIS
	a_roles_differ: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q != drain_q)
		else $error("fill and drain buffers coincide");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q[0] <= ppb_pkg::DEPTH_LEN && len_q[1] <= ppb_pkg::DEPTH_LEN)
		else $error("fill count above buffer depth");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		commit && res.start_transfer |=> act_q && drain_q == $past(fill_q))
		else $error("transfer start did not hand over the fill buffer");

	a_start_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		commit && res.start_transfer |-> res.byte_count != '0)
		else $error("transfer started with no data");
`endif

endmodule

/* rtl/core/ping_pong_tx_buffer_manager.sv */
// Ping-pong transmit buffer manager, top level: input register, buffer control, byte store
// and result register. Depends on ppb_pkg, ppb_ctrl and ppb_store.
//
// One item is accepted per cycle while the consumer takes results. The item is captured in
// the input register; its state update and store access happen when it leaves that register,
// at which edge the result register takes the result together with the byte from the store's
// registered read port. The result register can hold a result while the next item waits in
// the input register, so a stalled consumer costs no throughput until both are full.
module ping_pong_tx_buffer_manager (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  ppb_pkg::in_item_t  item,
	output logic               result_valid,
	input  logic               result_ready,
	output ppb_pkg::out_item_t result
);

	ppb_pkg::in_item_t  item_s1;
	logic               valid_s1;
	ppb_pkg::step_res_t res;
	ppb_pkg::step_res_t res_s2;
	ppb_pkg::wr_req_t   wr;
	ppb_pkg::rd_req_t   rd;
	logic [7:0]         rdata;
	logic               adv;

	assign adv = valid_s1 && (!result_valid || result_ready);
	assign item_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (item_valid && item_ready) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				result_valid <= 1'b1;
			end else if (result_ready) begin
				result_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
		if (adv) begin
			res_s2 <= res;
		end
	end

	ppb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.commit (adv),
		.item   (item_s1),
		.res    (res),
		.wr     (wr),
		.rd     (rd)
	);

	ppb_store u_store (
		.clk   (clk),
		.wr    (wr),
		.rd    (rd),
		.rdata (rdata)
	);

	always_comb begin
		result.accepted = res_s2.accepted;
		result.start_transfer = res_s2.start_transfer;
		result.transfer_buffer = res_s2.transfer_buffer;
		result.byte_count = res_s2.byte_count;
		result.engine_busy = res_s2.engine_busy;
		result.read_data = res_s2.read_hit ? rdata : 8'h00;
	end

endmodule

/* test/ping_pong_tx_buffer_manager_tb.sv */
// Testbench for ping_pong_tx_buffer_manager: drives put, transfer done, read and unused
// items, predicts every result with its own model of the two buffers and checks each field.
// Depends on ppb_pkg and the ping_pong_tx_buffer_manager RTL.
`timescale 1ns / 1ps

module ping_pong_tx_buffer_manager_tb;

	localparam int TOTAL_ITEMS = 1900;
	localparam int IDLE_LIMIT = 4000;

	logic               clk;
	logic               arst_n;
	logic               item_valid;
	logic               item_ready;
	ppb_pkg::in_item_t  item;
	logic               result_valid;
	logic               result_ready;
	ppb_pkg::out_item_t result;

	logic [7:0]         byte_mem [0:2*ppb_pkg::BUFFER_DEPTH-1];
	bit                 written_mem [0:2*ppb_pkg::BUFFER_DEPTH-1];
	int                 written_addrs [$];
	logic [6:0]         buf_len [0:1];
	logic               fill_sel;
	logic               drain_sel;
	logic               engine_on;
	ppb_pkg::out_item_t expected_results [$];

	int burst_left;
	int items_sent;
	int error_count;
	int idle_cycles;

	ping_pong_tx_buffer_manager dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic void clear_buffers();
		for (int i = 0; i < 2 * ppb_pkg::BUFFER_DEPTH; i++) begin
			byte_mem[i] = 8'h00;
			written_mem[i] = 1'b0;
		end
		written_addrs.delete();
		buf_len[0] = '0;
		buf_len[1] = '0;
		fill_sel = 1'b0;
		drain_sel = 1'b1;
		engine_on = 1'b0;
	endfunction

	// Hands the fill buffer to the engine when it is idle and the buffer holds data.
	function automatic bit try_handover(inout ppb_pkg::out_item_t r);
		if (engine_on || buf_len[fill_sel] == 0)
			return 1'b0;
		r.start_transfer = 1'b1;
		r.transfer_buffer = fill_sel;
		r.byte_count = buf_len[fill_sel];
		drain_sel = fill_sel;
		fill_sel = ~fill_sel;
		engine_on = 1'b1;
		return 1'b1;
	endfunction

	function automatic bit append_byte(logic [7:0] b, output bit flush);
		int a;
		logic [7:0] prev;
		flush = 1'b0;
		if (buf_len[fill_sel] >= ppb_pkg::BUFFER_DEPTH)
			return 1'b0;
		a = int'(fill_sel) * ppb_pkg::BUFFER_DEPTH + int'(buf_len[fill_sel]);
		byte_mem[a] = b;
		if (!written_mem[a]) begin
			written_mem[a] = 1'b1;
			written_addrs.push_back(a);
		end
		if (buf_len[fill_sel] != 0) begin
			prev = byte_mem[a-1];
			flush = (prev == ppb_pkg::CHAR_CR && b == ppb_pkg::CHAR_LF) ||
				(prev == ppb_pkg::CHAR_LF && b == ppb_pkg::CHAR_CR);
		end
		buf_len[fill_sel] = buf_len[fill_sel] + 7'd1;
		return 1'b1;
	endfunction

	function automatic ppb_pkg::out_item_t predict_tx_step(ppb_pkg::in_item_t it);
		ppb_pkg::out_item_t r;
		bit flush;
		r = '0;
		case (ppb_pkg::op_t'(it.operation))
			ppb_pkg::OP_PUT: begin
				if (append_byte(it.data_byte, flush)) begin
					r.accepted = 1'b1;
					if (flush)
						void'(try_handover(r));
				end else if (try_handover(r)) begin
					r.accepted = append_byte(it.data_byte, flush);
				end
			end
			ppb_pkg::OP_DONE: begin
				if (engine_on) begin
					engine_on = 1'b0;
					buf_len[drain_sel] = '0;
				end
				void'(try_handover(r));
			end
			ppb_pkg::OP_READ: begin
				r.read_data = byte_mem[{it.read_buffer, it.read_offset}];
			end
			default: begin
			end
		endcase
		r.engine_busy = engine_on;
		return r;
	endfunction

	function automatic ppb_pkg::in_item_t make_item(ppb_pkg::op_t op, logic [7:0] b);
		ppb_pkg::in_item_t it;
		it.operation = op;
		it.data_byte = b;
		it.read_buffer = 1'($urandom_range(0, 1));
		it.read_offset = 6'($urandom_range(0, 63));
		return it;
	endfunction

	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b == ppb_pkg::CHAR_CR || b == ppb_pkg::CHAR_LF);
		return b;
	endfunction

	task automatic send_item(ppb_pkg::in_item_t it);
		expected_results.push_back(predict_tx_step(it));
		if (burst_left == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 40);
		end
		item <= it;
		item_valid <= 1'b1;
		do
			@(posedge clk);
		while (!item_ready);
		@(negedge clk);
		burst_left--;
		items_sent++;
	endtask

	task automatic send_put(logic [7:0] b);
		send_item(make_item(ppb_pkg::OP_PUT, b));
	endtask

	task automatic send_done();
		send_item(make_item(ppb_pkg::OP_DONE, 8'($urandom_range(0, 255))));
	endtask

	task automatic send_read(logic rbuf, logic [5:0] roff);
		ppb_pkg::in_item_t it;
		it = make_item(ppb_pkg::OP_READ, 8'($urandom_range(0, 255)));
		it.read_buffer = rbuf;
		it.read_offset = roff;
		send_item(it);
	endtask

	task automatic send_unused();
		send_item(make_item(ppb_pkg::OP_NONE, 8'($urandom_range(0, 255))));
	endtask

	task automatic test_directed();
		send_put(8'h41);
		send_put(ppb_pkg::CHAR_CR);
		send_put(ppb_pkg::CHAR_LF);
		send_put(ppb_pkg::CHAR_LF);
		send_put(ppb_pkg::CHAR_CR);
		send_read(1'b0, 6'd0);
		send_read(1'b0, 6'd2);
		send_read(1'b1, 6'd1);
		send_unused();
		send_done();
		send_done();
		send_done();
		send_put(8'h00);
		send_put(8'hFF);
		send_done();
		send_put(ppb_pkg::CHAR_CR);
		send_put(ppb_pkg::CHAR_CR);
		send_put(ppb_pkg::CHAR_LF);
		send_read(1'b0, 6'd1);
		send_read(1'b1, 6'd2);
		send_unused();
		send_done();
		send_done();
	endtask

	// Fills a buffer while the engine is busy, then again while it is idle.
	task automatic test_full_buffer();
		logic full_buf;
		if (engine_on)
			send_done();
		send_put(plain_byte());
		send_done();
		full_buf = fill_sel;
		repeat (ppb_pkg::BUFFER_DEPTH) send_put(plain_byte());
		send_put(plain_byte());
		send_put(plain_byte());
		send_done();
		send_read(full_buf, 6'd63);
		send_read(full_buf, 6'd0);
		send_done();
		full_buf = fill_sel;
		repeat (ppb_pkg::BUFFER_DEPTH) send_put(plain_byte());
		send_put(8'($urandom_range(0, 255)));
		send_read(full_buf, 6'd63);
		send_read(~full_buf, 6'd0);
		send_done();
		send_done();
	endtask

	task automatic send_random_read();
		int a;
		a = written_addrs[$urandom_range(0, written_addrs.size() - 1)];
		send_read(1'(a / ppb_pkg::BUFFER_DEPTH), 6'(a % ppb_pkg::BUFFER_DEPTH));
	endtask

	// Lines of random bytes, half of them closed by a CR LF or LF CR pair, with transfer done
	// events at a rate that changes from line to line and some reads and unused codes.
	task automatic test_random_traffic();
		int done_odds;
		int line_len;
		int roll;
		while (items_sent < TOTAL_ITEMS) begin
			case ($urandom_range(0, 3))
				0: done_odds = 4;
				1: done_odds = 16;
				2: done_odds = 60;
				default: done_odds = 400;
			endcase
			line_len = $urandom_range(1, 90);
			for (int i = 0; i < line_len; i++) begin
				roll = $urandom_range(0, 99);
				if ($urandom_range(0, done_odds - 1) == 0)
					send_done();
				else if (roll < 6)
					send_random_read();
				else if (roll < 8)
					send_unused();
				else if ($urandom_range(0, 7) == 0)
					send_put($urandom_range(0, 1) ? ppb_pkg::CHAR_CR : ppb_pkg::CHAR_LF);
				else
					send_put(8'($urandom_range(0, 255)));
			end
			case ($urandom_range(0, 3))
				0: begin
				end
				1: begin
					send_put(ppb_pkg::CHAR_CR);
					send_put(ppb_pkg::CHAR_LF);
				end
				2: begin
					send_put(ppb_pkg::CHAR_LF);
					send_put(ppb_pkg::CHAR_CR);
				end
				default: send_done();
			endcase
		end
	endtask

	initial begin
		int stall_left;
		int stall_mode;
		int phase;
		stall_left = 0;
		stall_mode = 0;
		phase = 0;
		result_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				stall_left = $urandom_range(32, 256);
			end
			stall_left--;
			phase++;
			case (stall_mode)
				0: result_ready <= 1'b1;
				1: result_ready <= 1'($urandom_range(0, 1));
				2: result_ready <= ($urandom_range(0, 3) == 0);
				default: result_ready <= phase[2];
			endcase
		end
	end

	task automatic check_field(string name, int e, int a);
		if (e != a) begin
			$display("%0t: %s expected %0h, actual %0h", $time, name, e, a);
			error_count++;
		end
	endtask

	always @(posedge clk) begin
		ppb_pkg::out_item_t exp_res;
		if ((item_valid && item_ready) || (result_valid && result_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else if (result_valid && result_ready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: result with none expected, actual %0h", $time, result);
				error_count++;
			end else begin
				exp_res = expected_results.pop_front();
				check_field("accepted", exp_res.accepted, result.accepted);
				check_field("start_transfer", exp_res.start_transfer, result.start_transfer);
				check_field("transfer_buffer", exp_res.transfer_buffer,
					result.transfer_buffer);
				check_field("byte_count", exp_res.byte_count, result.byte_count);
				check_field("engine_busy", exp_res.engine_busy, result.engine_busy);
				check_field("read_data", exp_res.read_data, result.read_data);
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		burst_left = 0;
		items_sent = 0;
		error_count = 0;
		idle_cycles = 0;
		clear_buffers();
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_full_buffer();
		test_random_traffic();
		item_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

/* ping_pong_tx_buffer_manager.f */
rtl/core/ppb_pkg.sv
rtl/core/ppb_store.sv
rtl/core/ppb_ctrl.sv
rtl/core/ping_pong_tx_buffer_manager.sv
test/ping_pong_tx_buffer_manager_tb.sv
